// ----- rtl/table_linear_interpolator_defines.svh -----
// Assertion macros used by the RTL file tli_back.sv.
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");

`endif

// ----- rtl/tli_pkg.sv -----
`timescale 1ns / 1ps
package tli_pkg;
    localparam int INDEX_W      = 8;
    localparam int NUM_POINTS_W = 9;
    localparam int CFG_IDX_W    = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VALUE = 2'd2;

    typedef enum logic [1:0] {
        REG_INTERP = 2'd0,
        REG_EXACT  = 2'd1,
        REG_LEFT   = 2'd2,
        REG_RIGHT  = 2'd3
    } t_region;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_CHK1,
        ST_CHK0,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } t_state;
endpackage

// ----- rtl/tli_in_if.sv -----
`timescale 1ns / 1ps
interface tli_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [7:0]                  point_index;
    logic signed [VALUE_WIDTH-1:0] x_value;
    logic signed [VALUE_WIDTH-1:0] y_value;
    logic                        last_query;

    modport source (output valid, cmd, point_index, x_value, y_value, last_query,
                    input ready);
    modport sink   (input valid, cmd, point_index, x_value, y_value, last_query,
                    output ready);
endinterface

// ----- rtl/tli_out_if.sv -----
`timescale 1ns / 1ps
interface tli_out_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] y_out;
    logic [1:0]                    region;
    logic                          last_out;

    modport source (output valid, y_out, region, last_out, input ready);
    modport sink   (input valid, y_out, region, last_out, output ready);
endinterface

// ----- rtl/tli_front.sv -----
`timescale 1ns / 1ps
module tli_front #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tli_in_if.sink                        i_req,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output logic                          o_q_query,
    output logic                          o_q_load_ok,
    output logic [AW-1:0]                 o_q_addr,
    output logic signed [VALUE_WIDTH-1:0] o_q_x,
    output logic signed [VALUE_WIDTH-1:0] o_q_y,
    output logic                          o_q_last
);
    import tli_pkg::*;

    logic                          r_query [2];
    logic                          r_ok    [2];
    logic [AW-1:0]                 r_addr  [2];
    logic signed [VALUE_WIDTH-1:0] r_x     [2];
    logic signed [VALUE_WIDTH-1:0] r_y     [2];
    logic                          r_last  [2];
    logic                          r_wp, r_rp;
    logic [1:0]                    r_cnt;
    logic                          push;
    logic                          in_ok;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign in_ok       = (32'(i_req.point_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_query[r_wp] <= (i_req.cmd == CMD_QUERY);
            r_ok[r_wp]    <= in_ok;
            r_addr[r_wp]  <= AW'(i_req.point_index);
            r_x[r_wp]     <= i_req.x_value;
            r_y[r_wp]     <= i_req.y_value;
            r_last[r_wp]  <= i_req.last_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_query   = r_query[r_rp];
    assign o_q_load_ok = r_ok[r_rp];
    assign o_q_addr    = r_addr[r_rp];
    assign o_q_x       = r_x[r_rp];
    assign o_q_y       = r_y[r_rp];
    assign o_q_last    = r_last[r_rp];
endmodule

// ----- rtl/tli_back.sv -----
`timescale 1ns / 1ps
`include "table_linear_interpolator_defines.svh"
module tli_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  logic                          i_q_query,
    input  logic                          i_q_load_ok,
    input  logic [AW-1:0]                 i_q_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_q_x,
    input  logic signed [VALUE_WIDTH-1:0] i_q_y,
    input  logic                          i_q_last,
    input  logic [tli_pkg::NUM_POINTS_W-1:0] i_num_points,
    input  logic signed [VALUE_WIDTH-1:0] i_left_value,
    input  logic signed [VALUE_WIDTH-1:0] i_right_value,
    tli_out_if.source                     o_rsp
);
    import tli_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * W + 3;
    localparam int NW = $clog2(W + 2);

    logic signed [W-1:0] mem_x [TABLE_DEPTH];
    logic signed [W-1:0] mem_y [TABLE_DEPTH];

    t_state              r_state, n_state;
    logic [CW-1:0]       r_m, r_first, r_count, r_probe;
    logic signed [W-1:0] r_xq, r_x1, r_y0, r_y1, r_res;
    logic signed [W-1:0] r_rd_x, r_rd_y;
    logic                r_last, r_neg;
    t_region             r_reg;
    logic [W:0]          r_den, r_dy;
    logic [PW-1:0]       r_p;
    logic [NW-1:0]       r_step;

    logic                r_out_valid;
    logic signed [W-1:0] r_y_out;
    t_region             r_region;
    logic                r_last_out;

    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic                out_free;
    logic [CW-1:0]       m_sat, half;
    logic                step_last;
    logic signed [W:0]   dy_s, dx_s, den_s;
    logic [W+1:0]        mul_sum, div_tmp;
    logic                div_ge;
    logic [W:0]          quot;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign m_sat     = (32'(i_num_points) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                : CW'(i_num_points);
    assign half      = r_count >> 1;
    assign step_last = (r_step == NW'(W));

    assign dy_s  = {r_y1[W-1], r_y1} - {r_rd_y[W-1], r_rd_y};
    assign dx_s  = {r_xq[W-1], r_xq} - {r_rd_x[W-1], r_rd_x};
    assign den_s = {r_x1[W-1], r_x1} - {r_rd_x[W-1], r_rd_x};

    assign mul_sum = r_p[PW-2:W+1] + (r_p[0] ? {1'b0, r_dy} : '0);
    assign div_tmp = {r_p[2*W+1:W+1], r_p[W]};
    assign div_ge  = (div_tmp >= {1'b0, r_den});
    assign quot    = r_p[W:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid && i_q_query) n_state = ST_PROBE;
            ST_PROBE: begin
                if (r_count != '0) n_state = ST_CMP;
                else if (r_first == r_m) n_state = ST_DONE;
                else n_state = ST_CHK1;
            end
            ST_CMP:   n_state = ST_PROBE;
            ST_CHK1: begin
                if (r_rd_x == r_xq || r_first == '0) n_state = ST_DONE;
                else n_state = ST_CHK0;
            end
            ST_CHK0:  n_state = ST_MUL;
            ST_MUL:   if (step_last) n_state = ST_DIV;
            ST_DIV:   if (step_last) n_state = ST_ADD;
            ST_ADD:   n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        mem_we  = 1'b0;
        rd_addr = r_first[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = i_q_valid;
                mem_we  = i_q_valid && !i_q_query && i_q_load_ok;
            end
            ST_PROBE: if (r_count != '0) rd_addr = AW'(r_first + half);
            ST_CHK1:  rd_addr = AW'(r_first - CW'(1));
            default:  rd_addr = r_first[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[i_q_addr] <= i_q_x;
            mem_y[i_q_addr] <= i_q_y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_xq    <= i_q_x;
                r_last  <= i_q_last;
                r_first <= '0;
                r_count <= m_sat;
                r_m     <= m_sat;
            end
            ST_PROBE: begin
                r_probe <= r_first + half;
                if (r_count == '0 && r_first == r_m) begin
                    r_res <= i_right_value;
                    r_reg <= REG_RIGHT;
                end
            end
            ST_CMP: begin
                if (r_rd_x < r_xq) begin
                    r_first <= r_probe + CW'(1);
                    r_count <= r_count - half - CW'(1);
                end else begin
                    r_count <= half;
                end
            end
            ST_CHK1: begin
                r_x1 <= r_rd_x;
                r_y1 <= r_rd_y;
                if (r_rd_x == r_xq) begin
                    r_res <= r_rd_y;
                    r_reg <= REG_EXACT;
                end else begin
                    r_res <= i_left_value;
                    r_reg <= REG_LEFT;
                end
            end
            ST_CHK0: begin
                r_y0   <= r_rd_y;
                r_neg  <= dy_s[W];
                r_dy   <= dy_s[W] ? (W + 1)'(0) - dy_s : dy_s;
                r_den  <= den_s;
                r_p    <= {{(W + 2){1'b0}}, dx_s};
                r_step <= '0;
                r_reg  <= REG_INTERP;
            end
            ST_MUL: begin
                r_p    <= {1'b0, mul_sum, r_p[W:1]};
                r_step <= step_last ? '0 : r_step + NW'(1);
            end
            ST_DIV: begin
                r_p    <= {1'b0,
                           div_ge ? (W + 1)'(div_tmp - {1'b0, r_den}) : div_tmp[W:0],
                           r_p[W-1:0], div_ge};
                r_step <= r_step + NW'(1);
            end
            ST_ADD: begin
                r_res <= r_neg ? W'(r_y0 - quot[W-1:0]) : W'(r_y0 + quot[W-1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_y_out    <= r_res;
            r_region   <= r_reg;
            r_last_out <= r_last;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.y_out    = r_y_out;
    assign o_rsp.region   = r_region;
    assign o_rsp.last_out = r_last_out;

    `TLI_ASSERT_IMP(a_cmp_count, i_clk, i_rst_n, r_state == ST_CMP, r_count != '0)
    `TLI_ASSERT_IMP(a_div_den, i_clk, i_rst_n, r_state == ST_DIV, r_den != '0)
    `TLI_ASSERT_IMP(a_first_range, i_clk, i_rst_n, r_state != ST_IDLE, r_first <= r_m)
    `TLI_ASSERT_NXT(a_chk0_mul, i_clk, i_rst_n, r_state == ST_CHK0, r_state == ST_MUL)
endmodule

// ----- rtl/table_linear_interpolator.sv -----
`timescale 1ns / 1ps
// Piecewise linear table lookup on signed fixed point values.
// Request channel i_req: cmd selects a point load (writes point_index) or a
// query (x_value). Result channel o_rsp: one item per query, none per load,
// with y_out, region and last_out echoing last_query.
// Configuration: pulse i_cfg_we with i_cfg_idx 0 num_points, 1 left_value,
// 2 right_value; write only while no request is in flight.
// Requests pass a two-entry queue into a sequencer that owns the table.
// A load is written to the table as the sequencer pops it while idle. An
// interpolated query runs a binary search over the N active points, with a
// probe and a compare state per search step on the registered table read
// port, then a shift-add multiply and a restoring divide, one bit per step.
// Each result leaves through the output register.
// Reset clears the configuration to zero and empties queue and output; the
// table contents are undefined until loaded.
// A stalled receiver holds the result register; the queue keeps accepting
// until full, then i_req.ready drops.
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tli_in_if.sink                           i_req,
    tli_out_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [tli_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [((VALUE_WIDTH > 9) ? VALUE_WIDTH : 9)-1:0] i_cfg_data
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [NUM_POINTS_W-1:0]       r_num_points;
    logic signed [VALUE_WIDTH-1:0] r_left_value, r_right_value;

    logic                          q_valid, q_pop, q_query, q_load_ok, q_last;
    logic [AW-1:0]                 q_addr;
    logic signed [VALUE_WIDTH-1:0] q_x, q_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points  <= '0;
            r_left_value  <= '0;
            r_right_value <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_POINTS:  r_num_points  <= i_cfg_data[NUM_POINTS_W-1:0];
                CFG_LEFT_VALUE:  r_left_value  <= i_cfg_data[VALUE_WIDTH-1:0];
                CFG_RIGHT_VALUE: r_right_value <= i_cfg_data[VALUE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    tli_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_query   (q_query),
        .o_q_load_ok (q_load_ok),
        .o_q_addr    (q_addr),
        .o_q_x       (q_x),
        .o_q_y       (q_y),
        .o_q_last    (q_last)
    );

    tli_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_query     (q_query),
        .i_q_load_ok   (q_load_ok),
        .i_q_addr      (q_addr),
        .i_q_x         (q_x),
        .i_q_y         (q_y),
        .i_q_last      (q_last),
        .i_num_points  (r_num_points),
        .i_left_value  (r_left_value),
        .i_right_value (r_right_value),
        .o_rsp         (o_rsp)
    );
endmodule
